// File: rtl/core/pnsf_pkg.sv
// Shared types and constants for the pink noise shaping filter.
package pnsf_pkg;

	localparam int NUM_POLES  = 6;
	localparam int POLE_IDX_W = 3;
	localparam int COEF_W     = 18;
	localparam int SAMPLE_W   = 16;
	localparam int GAIN_W     = 24;
	localparam int STATE_W    = 32;

	localparam logic signed [COEF_W-1:0] POLE_COEF [NUM_POLES] = '{
		18'sd130923, 18'sd130196, 18'sd127009, 18'sd113574, 18'sd72090, -18'sd99824
	};
	localparam logic signed [COEF_W-1:0] IN_COEF [NUM_POLES] = '{
		18'sd7277, 18'sd9840, 18'sd20166, 18'sd40696, 18'sd69855, -18'sd2215
	};
	localparam logic signed [COEF_W-1:0] DIRECT_GAIN = 18'sd70281;
	localparam logic signed [COEF_W-1:0] DELAY_GAIN  = 18'sd15195;

	typedef enum logic {
		REG_NOISE_MODE  = 1'b0,
		REG_OUTPUT_GAIN = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_KX,
		OP_CP,
		OP_DIR,
		OP_DLY,
		OP_GAIN,
		OP_WHITE
	} op_t;

	typedef struct packed {
		op_t                   op;
		logic [POLE_IDX_W-1:0] pole;
		logic                  start;
		logic                  load_out;
		logic                  white;
	} cmd_t;

endpackage

// File: rtl/core/pnsf_datapath.sv
// Datapath of the pink noise shaping filter: shared multiplier, filter state, output register.
module pnsf_datapath (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  pnsf_pkg::cmd_t                         cmd,
	input  logic signed [pnsf_pkg::SAMPLE_W-1:0]   white_sample,
	input  logic [pnsf_pkg::GAIN_W-1:0]            output_gain,
	output logic signed [pnsf_pkg::SAMPLE_W-1:0]   noise_sample
);

	localparam int A_W    = 35;
	localparam int B_W    = 25;
	localparam int P_W    = A_W + B_W;
	localparam int ACC_W  = 52;

	localparam logic signed [ACC_W-1:0] S32_MAX = 52'sd2147483647;
	localparam logic signed [ACC_W-1:0] S32_MIN = -52'sd2147483648;
	localparam logic signed [P_W-1:0]   S16_MAX = 60'sd32767;
	localparam logic signed [P_W-1:0]   S16_MIN = -60'sd32768;
	localparam logic signed [P_W-1:0]   MASK_23 = 60'sd8388607;
	localparam logic signed [P_W-1:0]   MASK_32 = 60'sd4294967295;

	logic signed [pnsf_pkg::SAMPLE_W-1:0] x_q;
	logic signed [pnsf_pkg::STATE_W-1:0]  pole_q [pnsf_pkg::NUM_POLES];
	logic signed [pnsf_pkg::STATE_W-1:0]  delayed_q;
	logic signed [ACC_W-1:0]              acc_q;
	logic signed [A_W-1:0]                sum_q;
	logic signed [pnsf_pkg::SAMPLE_W-1:0] noise_sample_q;

	logic signed [A_W-1:0]   mul_a;
	logic signed [B_W-1:0]   mul_b;
	logic signed [P_W-1:0]   prod_s1;
	pnsf_pkg::op_t           op_s1;
	logic [pnsf_pkg::POLE_IDX_W-1:0] pole_s1;

	logic signed [ACC_W-1:0]              cp_sum;
	logic signed [ACC_W-1:0]              cp_shift;
	logic signed [pnsf_pkg::STATE_W-1:0]  pole_new;
	logic signed [P_W-1:0]                fin_adj;
	logic signed [P_W-1:0]                fin_shift;
	logic signed [pnsf_pkg::SAMPLE_W-1:0] fin_sat;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			pnsf_pkg::OP_KX: begin
				mul_a = A_W'(x_q);
				mul_b = B_W'(pnsf_pkg::IN_COEF[cmd.pole]);
			end
			pnsf_pkg::OP_CP: begin
				mul_a = A_W'(pole_q[cmd.pole]);
				mul_b = B_W'(pnsf_pkg::POLE_COEF[cmd.pole]);
			end
			pnsf_pkg::OP_DIR: begin
				mul_a = A_W'(x_q);
				mul_b = B_W'(pnsf_pkg::DIRECT_GAIN);
			end
			pnsf_pkg::OP_DLY: begin
				mul_a = A_W'(x_q);
				mul_b = B_W'(pnsf_pkg::DELAY_GAIN);
			end
			pnsf_pkg::OP_GAIN: begin
				mul_a = sum_q;
				mul_b = signed'({1'b0, output_gain});
			end
			pnsf_pkg::OP_WHITE: begin
				mul_a = A_W'(x_q);
				mul_b = signed'({1'b0, output_gain});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= pnsf_pkg::OP_NONE;
		end else begin
			op_s1 <= cmd.op;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op != pnsf_pkg::OP_NONE) begin
			prod_s1 <= mul_a * mul_b;
			pole_s1 <= cmd.pole;
		end
	end

	always_comb begin
		cp_sum   = acc_q + signed'(prod_s1[ACC_W-1:0]);
		cp_shift = cp_sum >>> 17;
		if (cp_shift > S32_MAX) begin
			pole_new = pnsf_pkg::STATE_W'(S32_MAX);
		end else if (cp_shift < S32_MIN) begin
			pole_new = pnsf_pkg::STATE_W'(S32_MIN);
		end else begin
			pole_new = cp_shift[pnsf_pkg::STATE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pnsf_pkg::NUM_POLES; i++) begin
				pole_q[i] <= '0;
			end
			delayed_q <= '0;
		end else begin
			if (op_s1 == pnsf_pkg::OP_CP) begin
				pole_q[pole_s1] <= pole_new;
			end
			if (op_s1 == pnsf_pkg::OP_DLY) begin
				delayed_q <= signed'(prod_s1[39:8]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			x_q   <= white_sample;
			sum_q <= '0;
		end else begin
			case (op_s1)
				pnsf_pkg::OP_KX:  acc_q <= signed'({prod_s1[42:0], 9'b0});
				pnsf_pkg::OP_CP:  sum_q <= sum_q + A_W'(pole_new);
				pnsf_pkg::OP_DIR: sum_q <= sum_q + signed'(prod_s1[42:8]) + A_W'(delayed_q);
				default: ;
			endcase
		end
	end

	always_comb begin
		if (prod_s1[P_W-1]) begin
			fin_adj = prod_s1 + (cmd.white ? MASK_23 : MASK_32);
		end else begin
			fin_adj = prod_s1;
		end
		fin_shift = cmd.white ? (fin_adj >>> 23) : (fin_adj >>> 32);
		if (fin_shift > S16_MAX) begin
			fin_sat = pnsf_pkg::SAMPLE_W'(S16_MAX);
		end else if (fin_shift < S16_MIN) begin
			fin_sat = pnsf_pkg::SAMPLE_W'(S16_MIN);
		end else begin
			fin_sat = fin_shift[pnsf_pkg::SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			noise_sample_q <= fin_sat;
		end
	end

	assign noise_sample = noise_sample_q;

endmodule

// File: rtl/core/pnsf_ctrl.sv
// Controller of the pink noise shaping filter: sequences the multiplier and the output transfer.
module pnsf_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           noise_mode,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output pnsf_pkg::cmd_t cmd
);

	localparam logic [3:0] STEP_DIR  = 4'd12;
	localparam logic [3:0] STEP_DLY  = 4'd13;
	localparam logic [3:0] STEP_GAIN = 4'd14;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FIN
	} state_t;

	state_t     state_q;
	logic [3:0] step_q;
	logic       white_q;
	logic       out_valid_q;
	logic       slot_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		cmd.op       = pnsf_pkg::OP_NONE;
		cmd.pole     = step_q[3:1];
		cmd.start    = in_valid && in_ready;
		cmd.load_out = (state_q == ST_FIN) && slot_free;
		cmd.white    = white_q;
		if (state_q == ST_RUN) begin
			if (white_q) begin
				cmd.op = pnsf_pkg::OP_WHITE;
			end else begin
				unique case (step_q)
					STEP_DIR:  cmd.op = pnsf_pkg::OP_DIR;
					STEP_DLY:  cmd.op = pnsf_pkg::OP_DLY;
					STEP_GAIN: cmd.op = pnsf_pkg::OP_GAIN;
					default:   cmd.op = step_q[0] ? pnsf_pkg::OP_CP : pnsf_pkg::OP_KX;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			white_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FIN && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_RUN;
						step_q  <= '0;
						white_q <= !noise_mode;
					end
				end
				ST_RUN: begin
					if (white_q || step_q == STEP_GAIN) begin
						state_q <= ST_FIN;
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				ST_FIN: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/core/pink_noise_shaping_filter.sv
// Top level of the pink noise shaping filter: configuration registers, controller and datapath.
// One white noise sample in, one 16-bit sample out, one item at a time. In pink mode an item
// is fifteen operations issued in turn to a single shared 35x25 multiplier (two per filter
// section, the direct and delayed terms, the final gain), then truncation and saturation into
// the output register. In white mode an item is one multiplication by the gain, then the same
// output step. The result register lets the next sample transfer in while a result waits; a
// result that still finds the register full holds the block until out_ready frees it.
module pink_noise_shaping_filter (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic                                 cfg_index,
	input  logic [pnsf_pkg::GAIN_W-1:0]          cfg_wdata,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [pnsf_pkg::SAMPLE_W-1:0] white_sample,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [pnsf_pkg::SAMPLE_W-1:0] noise_sample
);

	logic                          noise_mode_q;
	logic [pnsf_pkg::GAIN_W-1:0]   output_gain_q;
	pnsf_pkg::cmd_t                cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_mode_q  <= 1'b1;
			output_gain_q <= 24'd2621440;
		end else if (cfg_we) begin
			unique case (pnsf_pkg::reg_idx_t'(cfg_index))
				pnsf_pkg::REG_NOISE_MODE:  noise_mode_q  <= cfg_wdata[0];
				pnsf_pkg::REG_OUTPUT_GAIN: output_gain_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	pnsf_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.noise_mode (noise_mode_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.cmd        (cmd)
	);

	pnsf_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.white_sample (white_sample),
		.output_gain  (output_gain_q),
		.noise_sample (noise_sample)
	);

endmodule

// File: tb/pnsf_checker.sv
// Checker for the pink noise shaping filter: watches both channels and the register port.
module pnsf_checker
	import pnsf_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [GAIN_W-1:0]          cfg_wdata,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  logic signed [SAMPLE_W-1:0] white_sample,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  logic signed [SAMPLE_W-1:0] noise_sample,
	output int                         mismatch_count,
	output int                         pending_count
);

	localparam longint DIRECT_TAP = 70281;
	localparam longint DELAY_TAP  = 15195;

	logic                       pink_mode;
	logic [GAIN_W-1:0]          gain;
	logic signed [STATE_W-1:0]  section [NUM_POLES];
	logic signed [STATE_W-1:0]  held_term;
	logic signed [SAMPLE_W-1:0] expected_noise [$];
	logic signed [SAMPLE_W-1:0] want;

	function automatic longint section_pole(int i);
		case (i)
			0:       return 130923;
			1:       return 130196;
			2:       return 127009;
			3:       return 113574;
			4:       return 72090;
			default: return -99824;
		endcase
	endfunction

	function automatic longint section_gain(int i);
		case (i)
			0:       return 7277;
			1:       return 9840;
			2:       return 20166;
			3:       return 40696;
			4:       return 69855;
			default: return -2215;
		endcase
	endfunction

	function automatic longint toward_zero(longint v, int n);
		if (v < 0)
			return -((-v) >>> n);
		return v >>> n;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] clip16(longint v);
		if (v > 32767)
			return 16'sh7fff;
		if (v < -32768)
			return 16'sh8000;
		return v[SAMPLE_W-1:0];
	endfunction

	function automatic logic signed [STATE_W-1:0] clip32(longint v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return v[STATE_W-1:0];
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] predict_noise_sample(
		logic signed [SAMPLE_W-1:0] w);
		longint x;
		longint g;
		longint acc;
		longint sum;
		int     i;
		x = longint'(w);
		g = longint'(gain);
		if (!pink_mode)
			return clip16(toward_zero(x * g, 23));
		sum = 0;
		for (i = 0; i < NUM_POLES; i++) begin
			acc = section_pole(i) * longint'(section[i]) + (section_gain(i) * x) * 512;
			section[i] = clip32(acc >>> 17);
			sum += longint'(section[i]);
		end
		sum += longint'(held_term) + ((DIRECT_TAP * x) >>> 8);
		held_term = STATE_W'((DELAY_TAP * x) >>> 8);
		return clip16(toward_zero(sum * g, 32));
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pink_mode = 1'b1;
			gain = 24'd2621440;
			for (int k = 0; k < NUM_POLES; k++)
				section[k] = '0;
			held_term = '0;
			expected_noise.delete();
			mismatch_count = 0;
			pending_count = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_NOISE_MODE:  pink_mode = cfg_wdata[0];
					REG_OUTPUT_GAIN: gain = cfg_wdata;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_noise.size() == 0) begin
					$display("%0t: noise_sample expected none actual %0d", $time, noise_sample);
					mismatch_count++;
				end else begin
					want = expected_noise.pop_front();
					if (noise_sample !== want) begin
						$display("%0t: noise_sample expected %0d actual %0d",
							$time, want, noise_sample);
						mismatch_count++;
					end
				end
			end
			if (in_valid && in_ready)
				expected_noise.push_back(predict_noise_sample(white_sample));
			pending_count = expected_noise.size();
		end
	end

endmodule

// File: tb/tb.sv
// Testbench top for the pink noise shaping filter: clock, reset, stimulus and verdict.
module tb;
	import pnsf_pkg::*;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_we = 1'b0;
	logic                       cfg_index = REG_NOISE_MODE;
	logic [GAIN_W-1:0]          cfg_wdata = '0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic signed [SAMPLE_W-1:0] white_sample = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic signed [SAMPLE_W-1:0] noise_sample;
	int                         mismatch_count;
	int                         pending_count;
	int                         idle_odds = 4;

	pink_noise_shaping_filter u_top (.*);

	pnsf_checker u_check (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		forever begin
			@(negedge clk);
			if (arst_n && idle_odds != 0 && $urandom_range(idle_odds) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(15, 1)) @(negedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
		if (idle_odds != 0 && $urandom_range(idle_odds - 1) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(15, 1)) @(negedge clk);
		end
		in_valid <= 1'b1;
		white_sample <= s;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic drain_results();
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		while (pending_count != 0 && guard < 20000) begin
			@(negedge clk);
			guard++;
		end
		repeat (24) @(negedge clk);
	endtask

	task automatic set_config(input logic mode, input logic [GAIN_W-1:0] g);
		cfg_we <= 1'b1;
		cfg_index <= REG_NOISE_MODE;
		cfg_wdata <= {23'($urandom), mode};
		@(negedge clk);
		cfg_index <= REG_OUTPUT_GAIN;
		cfg_wdata <= g;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int                         phase;
		int                         count;
		int                         shape;
		int                         run_left;
		logic                       mode_sel;
		logic [GAIN_W-1:0]          gain_sel;
		logic signed [SAMPLE_W-1:0] held;
		logic signed [SAMPLE_W-1:0] s;

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: pink mode, default gain
		send_sample(16'sd0);
		send_sample(16'sh7fff);
		send_sample(16'sh7fff);
		send_sample(16'sh8000);
		send_sample(16'sh8000);
		send_sample(16'sd1);
		send_sample(-16'sd1);
		send_sample(16'sh5555);
		send_sample(16'shaaaa);

		// white mode at full gain: saturate both ways
		drain_results();
		set_config(1'b0, '1);
		send_sample(16'sh7fff);
		send_sample(16'sh8000);
		send_sample(16'sd1);
		send_sample(-16'sd1);
		send_sample(16'sd0);

		// white mode, zero and tiny gain: truncate toward zero
		drain_results();
		set_config(1'b0, '0);
		send_sample(16'sh7fff);
		send_sample(16'sh8000);
		drain_results();
		set_config(1'b0, 24'd1);
		send_sample(-16'sd1);
		send_sample(16'sh8000);

		// back to pink at full gain: state kept, output saturates
		drain_results();
		set_config(1'b1, '1);
		send_sample(16'sh7fff);
		send_sample(16'sh8000);
		send_sample(16'sd0);

		for (phase = 0; phase < 8; phase++) begin
			drain_results();
			mode_sel = ($urandom_range(3) != 0);
			case ($urandom_range(4))
				0:       gain_sel = GAIN_W'($urandom);
				1:       gain_sel = GAIN_W'($urandom_range(65535));
				2:       gain_sel = '1;
				3:       gain_sel = 24'd2621440;
				default: gain_sel = 24'd256;
			endcase
			case ($urandom_range(3))
				0:       idle_odds = 0;
				1:       idle_odds = 2;
				2:       idle_odds = 4;
				default: idle_odds = 16;
			endcase
			if (phase == 7) begin
				mode_sel = 1'b1;
				idle_odds = 0;
			end
			set_config(mode_sel, gain_sel);
			run_left = 0;
			for (count = 0; count < 150; count++) begin
				if (run_left == 0) begin
					shape = $urandom_range(4);
					run_left = (shape == 1) ? $urandom_range(400, 1) : $urandom_range(60, 1);
					held = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
				end
				case (shape)
					1:       s = held;
					2:       s = count[0] ? 16'sh7fff : 16'sh8000;
					3:       s = SAMPLE_W'(int'($urandom_range(64)) - 32);
					default: s = SAMPLE_W'($urandom);
				endcase
				send_sample(s);
				run_left--;
			end
		end

		drain_results();
		if (mismatch_count == 0 && pending_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// File: sim.f
rtl/core/pnsf_pkg.sv
rtl/core/pnsf_datapath.sv
rtl/core/pnsf_ctrl.sv
rtl/core/pink_noise_shaping_filter.sv
tb/pnsf_checker.sv
tb/tb.sv
